### hdl/clmt_pkg.sv
// clmt_pkg: shared types and constants for the coherency line monitor table
// used by clmt_tag_cam and coherency_line_monitor_table; no dependencies
`default_nettype none

package clmt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int SLOT_W        = 6;
   localparam int COUNT_W       = 7;
   localparam int CMP_W         = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
   localparam int TAG_W         = 64;
   localparam int CTR_W         = 32;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [TAG_W-1:0]  tag_type;
   typedef logic [CTR_W-1:0]  ctr_type;

   typedef enum logic [2:0] {
      OP_INSERT     = 3'd0,
      OP_UPDATE     = 3'd1,
      OP_SNOOP_HIT  = 3'd2,
      OP_SNOOP_MISS = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_READ       = 3'd5
   } op_type;

   localparam logic [2:0] ST_SHARED    = 3'd1;
   localparam logic [2:0] ST_EXCLUSIVE = 3'd2;
   localparam logic [2:0] ST_MODIFIED  = 3'd3;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   // payload word kept in the entry memory
   typedef struct packed {
      logic [2:0] state;
      logic       dirty;
      ctr_type    accesses;
      tag_type    stamp;
   } entry_type;

   // tag lookup result
   typedef struct packed {
      logic    hit;
      idx_type idx;
   } match_type;

   // tag write request
   typedef struct packed {
      logic    en;
      idx_type idx;
      tag_type tag;
   } tag_wr_type;

endpackage

`default_nettype wire

### hdl/clmt_tag_cam.sv
// clmt_tag_cam: tag registers with parallel compare and lowest-slot select
// depends on clmt_pkg
`default_nettype none

module clmt_tag_cam (
   input  wire                  clock,
   input  clmt_pkg::tag_wr_type tag_wr,
   input  clmt_pkg::fill_type   fill,
   input  clmt_pkg::tag_type    lookup_addr,
   output clmt_pkg::match_type  match
);

   clmt_pkg::tag_type tag_ff [clmt_pkg::TABLE_ENTRIES];
   logic [clmt_pkg::TABLE_ENTRIES-1:0] eq;

   always_ff @(posedge clock) begin
      if (tag_wr.en) begin
         tag_ff[tag_wr.idx] <= tag_wr.tag;
      end
   end

   always_comb begin
      for (int i = 0; i < clmt_pkg::TABLE_ENTRIES; i++) begin
         eq[i] = (tag_ff[i] == lookup_addr) && (clmt_pkg::fill_type'(i) < fill);
      end
   end

   // lowest matching slot wins
   always_comb begin
      match.hit = |eq;
      match.idx = '0;
      for (int i = clmt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (eq[i]) begin
            match.idx = clmt_pkg::idx_type'(i);
         end
      end
   end

endmodule

`default_nettype wire

### hdl/coherency_line_monitor_table.sv
// coherency_line_monitor_table: top level, entry memory, control and counters
// depends on clmt_pkg and clmt_tag_cam
//
// usage
//   req_* channel carries one operation per transaction (valid/ready);
//   rsp_* channel returns exactly one result per operation, in order.
//   an accepted transaction is looked up in the tag registers in the
//   accept cycle and the entry memory is read then; the exec state that
//   follows does the read-modify-write of the entry and the counters and
//   loads the result register, which drives rsp_valid. a new transaction
//   is taken only once the last one has left the exec state, since the
//   registered entry memory read is followed by its write-back.
//   req_ready is high only while no transaction is in progress.
//   when rsp_ready is low the finished result waits in the output
//   register; the next transaction is still accepted and holds in its
//   write-back cycle until the output register frees.
//   reset clears the entry count and the three counters at once;
//   entry contents are not cleared and need no clearing pass.
`default_nettype none

module coherency_line_monitor_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_op,
   input  wire  [63:0] req_line_address,
   input  wire  [2:0]  req_new_state,
   input  wire  [5:0]  req_entry_index,
   input  wire  [63:0] req_tick_now,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_ok,
   output logic [5:0]  rsp_slot,
   output logic [2:0]  rsp_line_state,
   output logic        rsp_line_dirty,
   output logic [31:0] rsp_line_accesses,
   output logic [63:0] rsp_line_stamp,
   output logic [6:0]  rsp_entry_count,
   output logic [31:0] rsp_transactions,
   output logic [31:0] rsp_hits_seen,
   output logic [31:0] rsp_misses_seen
);

   // state machine
   clmt_pkg::fsm_type fsm_ff, fsm_in;
   logic accept;
   logic exec_go;

   // captured request
   clmt_pkg::op_type  op_ff;
   logic [2:0]        nst_ff;
   clmt_pkg::tag_type addr_ff;
   clmt_pkg::tag_type tick_ff;
   logic              hit_ff;
   logic              rd_ok_ff;
   clmt_pkg::idx_type slot_ff;

   // global state
   clmt_pkg::fill_type fill_ff, fill_in;
   clmt_pkg::ctr_type  trans_ff, trans_in;
   clmt_pkg::ctr_type  hits_ff, hits_in;
   clmt_pkg::ctr_type  miss_ff, miss_in;

   // entry memory
   clmt_pkg::entry_type pay_mem [clmt_pkg::TABLE_ENTRIES];
   clmt_pkg::entry_type pay_rd_ff;
   clmt_pkg::idx_type   rd_addr;
   logic                mem_wr;
   clmt_pkg::idx_type   mem_wr_idx;
   clmt_pkg::entry_type mem_wr_data;

   // tag lookup
   clmt_pkg::match_type  match;
   clmt_pkg::tag_wr_type tag_wr;

   // result
   logic                rsp_valid_ff, rsp_valid_in;
   logic                res_ok;
   clmt_pkg::idx_type   res_idx;
   clmt_pkg::entry_type res_entry;
   logic                     ok_ff;
   clmt_pkg::slot_type       slot_out_ff;
   clmt_pkg::entry_type      entry_out_ff;
   clmt_pkg::count_type      count_out_ff;
   clmt_pkg::ctr_type        trans_out_ff, hits_out_ff, miss_out_ff;

   clmt_tag_cam u_tag_cam (
      .clock       (clock),
      .tag_wr      (tag_wr),
      .fill        (fill_ff),
      .lookup_addr (req_line_address),
      .match       (match)
   );

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         clmt_pkg::FSM_IDLE: begin
            if (req_valid) fsm_in = clmt_pkg::FSM_EXEC;
         end
         clmt_pkg::FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) fsm_in = clmt_pkg::FSM_IDLE;
         end
         default: fsm_in = clmt_pkg::FSM_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready = 1'b0;
      exec_go   = 1'b0;
      case (fsm_ff)
         clmt_pkg::FSM_IDLE: req_ready = 1'b1;
         clmt_pkg::FSM_EXEC: exec_go = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            exec_go   = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= clmt_pkg::FSM_IDLE;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   // request capture and lookup result
   always_comb begin
      if (clmt_pkg::op_type'(req_op) == clmt_pkg::OP_READ) begin
         rd_addr = clmt_pkg::idx_type'(req_entry_index);
      end else begin
         rd_addr = match.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= clmt_pkg::op_type'(req_op);
         nst_ff   <= req_new_state;
         addr_ff  <= req_line_address;
         tick_ff  <= req_tick_now;
         hit_ff   <= match.hit;
         rd_ok_ff <= clmt_pkg::cmp_type'(req_entry_index) < clmt_pkg::cmp_type'(fill_ff);
         slot_ff  <= rd_addr;
      end
   end

   // entry memory, read at accept, written back in the exec cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         pay_mem[mem_wr_idx] <= mem_wr_data;
      end
      if (accept) begin
         pay_rd_ff <= pay_mem[rd_addr];
      end
   end

   // read-modify-write of the addressed entry
   always_comb begin
      fill_in     = fill_ff;
      trans_in    = trans_ff;
      hits_in     = hits_ff;
      miss_in     = miss_ff;
      mem_wr      = 1'b0;
      mem_wr_idx  = slot_ff;
      mem_wr_data = pay_rd_ff;
      tag_wr.en   = 1'b0;
      tag_wr.idx  = clmt_pkg::idx_type'(fill_ff);
      tag_wr.tag  = addr_ff;
      res_ok      = 1'b0;
      res_idx     = slot_ff;
      res_entry   = pay_rd_ff;
      case (op_ff)
         clmt_pkg::OP_INSERT: begin
            if (fill_ff != clmt_pkg::fill_type'(clmt_pkg::TABLE_ENTRIES)) begin
               mem_wr               = exec_go;
               mem_wr_idx           = clmt_pkg::idx_type'(fill_ff);
               mem_wr_data.state    = clmt_pkg::ST_EXCLUSIVE;
               mem_wr_data.dirty    = 1'b0;
               mem_wr_data.accesses = clmt_pkg::ctr_type'(1);
               mem_wr_data.stamp    = tick_ff;
               tag_wr.en            = exec_go;
               fill_in              = fill_ff + 1'b1;
               res_ok               = 1'b1;
               res_idx              = clmt_pkg::idx_type'(fill_ff);
               res_entry            = mem_wr_data;
            end
         end
         clmt_pkg::OP_UPDATE: begin
            if (hit_ff) begin
               mem_wr               = exec_go;
               mem_wr_data.state    = nst_ff;
               mem_wr_data.dirty    = pay_rd_ff.dirty || (nst_ff == clmt_pkg::ST_MODIFIED);
               mem_wr_data.accesses = pay_rd_ff.accesses + 1'b1;
               mem_wr_data.stamp    = tick_ff;
               trans_in             = trans_ff + 1'b1;
               res_ok               = 1'b1;
               res_entry            = mem_wr_data;
            end
         end
         clmt_pkg::OP_SNOOP_HIT: begin
            hits_in  = hits_ff + 1'b1;
            trans_in = trans_ff + 1'b1;
            if (hit_ff) begin
               mem_wr = exec_go;
               if (pay_rd_ff.state == clmt_pkg::ST_EXCLUSIVE) begin
                  mem_wr_data.state = clmt_pkg::ST_SHARED;
               end
               res_ok    = 1'b1;
               res_entry = mem_wr_data;
            end
         end
         clmt_pkg::OP_SNOOP_MISS: begin
            miss_in  = miss_ff + 1'b1;
            trans_in = trans_ff + 1'b1;
         end
         clmt_pkg::OP_CLEAR: begin
            fill_in = '0;
         end
         clmt_pkg::OP_READ: begin
            res_ok = rd_ok_ff;
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         trans_ff <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
      end else if (exec_go) begin
         fill_ff  <= fill_in;
         trans_ff <= trans_in;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
      end
   end

   // output register
   always_comb begin
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         ok_ff        <= res_ok;
         slot_out_ff  <= res_ok ? clmt_pkg::slot_type'(res_idx) : '0;
         entry_out_ff <= res_ok ? res_entry : '0;
         count_out_ff <= clmt_pkg::count_type'(fill_in);
         trans_out_ff <= trans_in;
         hits_out_ff  <= hits_in;
         miss_out_ff  <= miss_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_slot          = slot_out_ff;
   assign rsp_line_state    = entry_out_ff.state;
   assign rsp_line_dirty    = entry_out_ff.dirty;
   assign rsp_line_accesses = entry_out_ff.accesses;
   assign rsp_line_stamp    = entry_out_ff.stamp;
   assign rsp_entry_count   = count_out_ff;
   assign rsp_transactions  = trans_out_ff;
   assign rsp_hits_seen     = hits_out_ff;
   assign rsp_misses_seen   = miss_out_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= clmt_pkg::fill_type'(clmt_pkg::TABLE_ENTRIES))
      else $error("entry count above table size");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> fsm_ff == clmt_pkg::FSM_EXEC)
      else $error("accepted transaction not executed");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec_go))
      else $error("result appeared without exec");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == clmt_pkg::FSM_EXEC && !exec_go) |=>
         (fsm_ff == clmt_pkg::FSM_EXEC && $stable(op_ff) && $stable(slot_ff) &&
          $stable(fill_ff)))
      else $error("stalled exec lost its data");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (mem_wr || tag_wr.en) |-> exec_go)
      else $error("table written outside exec");
`endif

endmodule

`default_nettype wire
